FILE: rtl/core/rde_pkg.sv
package rde_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int CMD_W           = 2;
    localparam int FIELD_W         = 16;
    localparam int STATUS_W        = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_REVERSE = 2'd1,
        CMD_DELETE  = 2'd2,
        CMD_EMIT    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ELEMENT = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ERROR   = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [FIELD_W-1:0] value;
    } op_t;

endpackage

FILE: rtl/core/rde_ram.sv
module rde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/rde_front.sv
module rde_front
    import rde_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [FIELD_W-1:0] s_push_value,
    output logic               q_valid,
    output op_t                q_op,
    input  logic               q_pop
);

    localparam int QDEPTH = 2;

    op_t        ent_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    op_t        op_in;

    always_comb begin
        op_in.cmd   = cmd_t'(s_cmd);
        op_in.value = (op_in.cmd == CMD_PUSH) ? s_push_value : '0;
    end

    assign s_ready = (cnt_reg != 2'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

FILE: rtl/core/rde_back.sv
module rde_back
    import rde_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  op_t                 q_op,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [FIELD_W-1:0]  m_element,
    output logic                m_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            rev_reg, rev_next;
    logic            err_reg, err_next;

    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic            dir_reg, dir_next;
    logic            pend_reg, pend_next;
    logic            pend_last_reg, pend_last_next;

    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg, out_status_next;
    logic [FIELD_W-1:0] out_element_reg, out_element_next;
    logic            out_last_reg, out_last_next;

    logic            out_free;
    logic [CW:0]     tail_sum, last_sum;
    logic [AW-1:0]   tail_slot, last_slot, head_inc, ptr_step;
    logic            wr_en, rd_en;
    logic [VALUE_WIDTH-1:0] wr_data, rd_data;
    logic [FIELD_W-1:0]     rd_elem;

    rde_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_slot),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        tail_sum  = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        last_sum  = tail_sum - (CW+1)'(1);
        tail_slot = (tail_sum >= (CW+1)'(DEPTH)) ? AW'(tail_sum - (CW+1)'(DEPTH))
                                                  : AW'(tail_sum);
        last_slot = (last_sum >= (CW+1)'(DEPTH)) ? AW'(last_sum - (CW+1)'(DEPTH))
                                                  : AW'(last_sum);
        head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        if (dir_reg) begin
            ptr_step = (ptr_reg == '0) ? AW'(DEPTH - 1) : ptr_reg - AW'(1);
        end else begin
            ptr_step = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + AW'(1);
        end
        wr_data          = '0;
        wr_data[MW-1:0]  = q_op.value[MW-1:0];
        rd_elem          = '0;
        rd_elem[MW-1:0]  = rd_data[MW-1:0];
    end

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        rev_next         = rev_reg;
        err_next         = err_reg;
        ptr_next         = ptr_reg;
        rem_next         = rem_reg;
        dir_next         = dir_reg;
        pend_next        = pend_reg;
        pend_last_next   = pend_last_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_status_next  = out_status_reg;
        out_element_next = out_element_reg;
        out_last_next    = out_last_reg;
        q_pop            = 1'b0;
        wr_en            = 1'b0;
        rd_en            = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    case (q_op.cmd)
                        CMD_PUSH: begin
                            q_pop = 1'b1;
                            if (!err_reg) begin
                                if (count_reg == CW'(DEPTH)) begin
                                    err_next = 1'b1;
                                end else begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                        end
                        CMD_REVERSE: begin
                            q_pop = 1'b1;
                            if (!err_reg) begin
                                rev_next = !rev_reg;
                            end
                        end
                        CMD_DELETE: begin
                            q_pop = 1'b1;
                            if (!err_reg) begin
                                if (count_reg == '0) begin
                                    err_next = 1'b1;
                                end else begin
                                    if (!rev_reg) begin
                                        head_next = head_inc;
                                    end
                                    count_next = count_reg - CW'(1);
                                end
                            end
                        end
                        CMD_EMIT: begin
                            if (err_reg || count_reg == '0) begin
                                if (out_free) begin
                                    q_pop            = 1'b1;
                                    out_valid_next   = 1'b1;
                                    out_status_next  = err_reg ? ST_ERROR : ST_EMPTY;
                                    out_element_next = '0;
                                    out_last_next    = 1'b1;
                                    head_next        = '0;
                                    count_next       = '0;
                                    rev_next         = 1'b0;
                                    err_next         = 1'b0;
                                end
                            end else begin
                                q_pop      = 1'b1;
                                ptr_next   = rev_reg ? last_slot : head_reg;
                                rem_next   = count_reg;
                                dir_next   = rev_reg;
                                pend_next  = 1'b0;
                                head_next  = '0;
                                count_next = '0;
                                rev_next   = 1'b0;
                                state_next = S_EMIT;
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (pend_reg && out_free) begin
                    out_valid_next   = 1'b1;
                    out_status_next  = ST_ELEMENT;
                    out_element_next = rd_elem;
                    out_last_next    = pend_last_reg;
                end
                if (rem_reg != '0 && (!pend_reg || out_free)) begin
                    rd_en          = 1'b1;
                    ptr_next       = ptr_step;
                    rem_next       = rem_reg - CW'(1);
                    pend_last_next = (rem_reg == CW'(1));
                    pend_next      = 1'b1;
                end else begin
                    pend_next = pend_reg && !out_free;
                    if (rem_reg == '0 && (!pend_reg || out_free)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            err_reg       <= 1'b0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            err_reg       <= err_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg         <= ptr_next;
        dir_reg         <= dir_next;
        pend_last_reg   <= pend_last_next;
        out_status_reg  <= out_status_next;
        out_element_reg <= out_element_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_status  = out_status_reg;
    assign m_element = out_element_reg;
    assign m_last    = out_last_reg;

endmodule

FILE: rtl/core/reversible_deque_engine.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_cmd, s_push_value
// m_        out        m_valid / m_ready  m_status, m_element, m_last
//
// Push, reverse and delete are each executed directly in the executor's idle state.
// A non-empty emit streams its elements from the emit state; an empty or error emit gives a single result.
// The element stream runs one per cycle while m_ready is high, paced by the store's registered read port.
// A two-entry request queue accepts up to two further requests while an emit streams.
// Reset is synchronous and active low; the store itself is not cleared.
// m_ready low holds the output register and stalls the stream.
module reversible_deque_engine
    import rde_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [FIELD_W-1:0]  s_push_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [FIELD_W-1:0]  m_element,
    output logic                m_last
);

    logic q_valid;
    op_t  q_op;
    logic q_pop;

    rde_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_push_value (s_push_value),
        .q_valid      (q_valid),
        .q_op         (q_op),
        .q_pop        (q_pop)
    );

    rde_back #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_element (m_element),
        .m_last    (m_last)
    );

endmodule

FILE: rtl/core/rde_checker.sv
module rde_checker
    import rde_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [CMD_W-1:0]    s_cmd,
    input logic [FIELD_W-1:0]  s_push_value,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [FIELD_W-1:0]  m_element,
    input logic                m_last
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_cmd) && $stable(s_push_value))
        else $error("input request changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_element)
            && $stable(m_last))
        else $error("output request changed while stalled");

    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_ELEMENT |-> m_last)
        else $error("empty or error result not marked last");

    a_single_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_ELEMENT |-> m_element == '0)
        else $error("empty or error result carries an element");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_ELEMENT || m_status == ST_EMPTY
            || m_status == ST_ERROR)
        else $error("undefined status code");

endmodule

bind reversible_deque_engine rde_checker u_chk (.*);

FILE: sim/reversible_deque_engine_tb.sv
module reversible_deque_engine_tb;
    import rde_pkg::*;

    localparam int LIMIT = 300000;

    typedef struct packed {
        status_t            status;
        logic [FIELD_W-1:0] element;
        logic               last;
    } deque_result_t;

    class deque_scoreboard;
        logic [FIELD_W-1:0] slots [DEPTH_DEF];
        logic [5:0]         head;
        logic [6:0]         count;
        bit                 reversed;
        bit                 errored;
        deque_result_t      expected_q [$];
        int unsigned        errors;

        function new();
            head     = '0;
            count    = '0;
            reversed = 0;
            errored  = 0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(cmd_t c, logic [FIELD_W-1:0] v);
            logic [6:0]    off;
            logic [5:0]    slot;
            deque_result_t r;
            case (c)
                CMD_PUSH: begin
                    if (!errored) begin
                        if (count >= DEPTH_DEF) begin
                            errored = 1;
                        end else begin
                            slot = head + count[5:0];
                            slots[slot] = v;
                            count++;
                        end
                    end
                end
                CMD_REVERSE: begin
                    if (!errored) reversed = !reversed;
                end
                CMD_DELETE: begin
                    if (!errored) begin
                        if (count == 0) begin
                            errored = 1;
                        end else begin
                            if (!reversed) head++;
                            count--;
                        end
                    end
                end
                default: begin
                    if (errored) begin
                        r = '{ST_ERROR, '0, 1'b1};
                        expected_q = {expected_q, r};
                    end else if (count == 0) begin
                        r = '{ST_EMPTY, '0, 1'b1};
                        expected_q = {expected_q, r};
                    end else begin
                        for (int i = 0; i < count; i++) begin
                            off  = reversed ? (count - 7'd1 - 7'(i)) : 7'(i);
                            slot = head + off[5:0];
                            r = '{ST_ELEMENT, slots[slot], (i + 1 == count)};
                            expected_q = {expected_q, r};
                        end
                    end
                    head     = '0;
                    count    = '0;
                    reversed = 0;
                    errored  = 0;
                end
            endcase
        endfunction

        function void check_result(status_t st, logic [FIELD_W-1:0] el, logic lst);
            deque_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: status %0d element %h last %b",
                         $time, st, el, lst);
                errors++;
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (want.status !== st || want.element !== el || want.last !== lst) begin
                $display("%0t: expected status %0d element %h last %b, got %0d %h %b",
                         $time, want.status, want.element, want.last, st, el, lst);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [CMD_W-1:0]   s_cmd = '0;
    logic [FIELD_W-1:0] s_push_value = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [STATUS_W-1:0] m_status;
    logic [FIELD_W-1:0] m_element;
    logic               m_last;

    deque_scoreboard sb;
    bit              calm = 0;
    int unsigned     applied = 0;
    int unsigned     cycles = 0;

    reversible_deque_engine dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_element    (m_element),
        .m_last       (m_last)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** reversible_deque_engine: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(status_t'(m_status), m_element, m_last);
        m_ready <= calm || ($urandom_range(99) >= 38);
    end

    task automatic send_request(cmd_t c, logic [FIELD_W-1:0] v);
        while (!calm && $urandom_range(99) < 38) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid      <= 1;
        s_cmd        <= c;
        s_push_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (c == CMD_EMIT || !sb.errored) applied++;
        sb.note_request(c, v);
    endtask

    task automatic push_value(logic [FIELD_W-1:0] v);
        send_request(CMD_PUSH, v);
    endtask

    // random run: pushes (sometimes past the depth) with scattered reverses and deletes, maybe extra deletes, then emit
    task automatic run_sequence();
        int unsigned n;
        n = ($urandom_range(10) == 0) ? $urandom_range(62, 67) : $urandom_range(0, 9);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 20) send_request(CMD_REVERSE, 16'($urandom));
            if ($urandom_range(99) < 15) send_request(CMD_DELETE, 16'($urandom));
            push_value(16'($urandom_range(65535)));
        end
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) send_request(CMD_DELETE, 16'($urandom));
        end
        send_request(CMD_EMIT, 16'($urandom));
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_request(CMD_EMIT, 16'h0000);
        push_value(16'h0000);
        push_value(16'hFFFF);
        push_value(16'hA5A5);
        send_request(CMD_EMIT, 16'hFFFF);
        push_value(16'h0001);
        push_value(16'h0002);
        send_request(CMD_REVERSE, 16'h0000);
        push_value(16'h0003);
        send_request(CMD_EMIT, 16'h0000);
        push_value(16'h0010);
        push_value(16'h0020);
        push_value(16'h0030);
        send_request(CMD_REVERSE, 16'h0000);
        send_request(CMD_DELETE, 16'h0000);
        send_request(CMD_REVERSE, 16'h0000);
        send_request(CMD_DELETE, 16'h0000);
        send_request(CMD_EMIT, 16'h0000);
        // delete on empty, then ignored commands until emit
        send_request(CMD_DELETE, 16'h0000);
        push_value(16'h5555);
        send_request(CMD_REVERSE, 16'h0000);
        send_request(CMD_DELETE, 16'h0000);
        send_request(CMD_EMIT, 16'h0000);
        send_request(CMD_REVERSE, 16'h0000);
        send_request(CMD_EMIT, 16'h0000);

        applied = 0;
        while (applied < 210) begin
            calm = (applied >= 90 && applied < 140);
            if ($urandom_range(7) == 0)
                send_request(cmd_t'($urandom_range(3)), 16'($urandom));
            else
                run_sequence();
        end
        calm = 0;
        send_request(CMD_EMIT, 16'h0000);
        s_valid <= 0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("** reversible_deque_engine: PASSED **");
        end else begin
            $display("** reversible_deque_engine: FAILED **");
        end
        $finish;
    end

endmodule
